[hw/rtl/ctt_pkg.sv]
// Shared types and constants for the confirmation timeout table.
`timescale 1ns / 1ps
package ctt_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int MAX_RESULTS     = 16;
  localparam int RPT_W           = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_TICK   = 2'd1,
    OP_FIND   = 2'd2,
    OP_REMOVE = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    STAT_ADDED   = 3'd0,
    STAT_FULL    = 3'd1,
    STAT_FOUND   = 3'd2,
    STAT_MISSING = 3'd3,
    STAT_REMOVED = 3'd4,
    STAT_TIMEOUT = 3'd5
  } status_t;

  // Packed so that port lands in the lowest bits of a stream word.
  typedef struct packed {
    logic [15:0] ticks;
    logic [15:0] msg_id;
    logic [7:0]  smb;
    logic [31:0] hw_addr;
    logic [7:0]  port;
  } entry_t;

  typedef enum logic [2:0] {
    CO_HOLD   = 3'd0,
    CO_ADD    = 3'd1,
    CO_MARK   = 3'd2,
    CO_REMOVE = 3'd3,
    CO_ROTATE = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     keep;
    entry_t   bus;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_TICK = 2'd2
  } state_t;

endpackage

[hw/rtl/ctt_cell.sv]
// One table slot: holds an entry, compares its key, and shifts from its neighbor.
`timescale 1ns / 1ps
module ctt_cell import ctt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cell_cmd_t cmd,
  input  logic      prev_valid,
  input  logic      next_valid,
  input  logic      next_pending,
  input  entry_t    next_entry,
  input  logic      hit_in,
  output logic      hit_out,
  output logic      first,
  output logic      valid,
  output logic      pending,
  output entry_t    entry
);

  logic   match;
  logic   valid_next;
  logic   pending_next;
  entry_t entry_next;

  assign match = valid && (entry.port == cmd.bus.port) && (entry.hw_addr == cmd.bus.hw_addr)
                 && (entry.smb == cmd.bus.smb) && (entry.msg_id == cmd.bus.msg_id);
  assign first   = match && !hit_in;
  assign hit_out = hit_in || match;

  always_comb begin
    valid_next   = valid;
    pending_next = pending;
    entry_next   = entry;
    unique case (cmd.op)
      CO_ADD: begin
        if (!valid && prev_valid) begin
          valid_next   = 1'b1;
          pending_next = 1'b0;
          entry_next   = cmd.bus;
        end
      end
      CO_MARK: begin
        pending_next = valid;
      end
      CO_REMOVE: begin
        if (hit_out) begin
          valid_next   = next_valid;
          pending_next = next_pending;
          entry_next   = next_entry;
        end
      end
      CO_ROTATE: begin
        if (next_valid) begin
          valid_next   = 1'b1;
          pending_next = next_pending;
          entry_next   = next_entry;
        end else if (valid) begin
          valid_next   = cmd.keep;
          pending_next = 1'b0;
          entry_next   = cmd.bus;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      pending <= 1'b0;
    end else begin
      valid   <= valid_next;
      pending <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

[hw/rtl/confirmation_timeout_table.sv]
// Top level of the confirmation timeout table: a row of slot cells and its sequencer.
// Add, find and remove are accepted in S_IDLE and act on all slots at once in S_EXEC,
// once the output register is free. A tick marks the valid entries pending in S_IDLE,
// then in S_TICK the table rotates through slot 0, which decrements or drops one
// entry per cycle unless a report is held up. Timed-out entries, up to MAX_RESULTS, are
// reported oldest first, one per transaction, and the rotation waits while a report is
// stuck behind a busy output. Valid entries always sit at the low slots, oldest first.
`timescale 1ns / 1ps
module confirmation_timeout_table import ctt_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // port, hw_addr, smb, msg_id, ticks
  input  logic [1:0]  s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // out_port, out_hw_addr, out_smb, out_msg_id, out_ticks_left
  output logic [2:0]  m_tuser,   // status
  output logic        m_tlast
);

  state_t     state;
  state_t     state_next;
  opcode_t    op_r;
  entry_t     key_r;
  cell_cmd_t  cmd;

  logic       valid   [TABLE_DEPTH + 1];
  logic       pending [TABLE_DEPTH + 1];
  entry_t     entries [TABLE_DEPTH + 1];
  logic       hit     [TABLE_DEPTH + 1];
  logic       first   [TABLE_DEPTH];
  entry_t     sel;

  logic       out_valid;
  logic       out_ld;
  status_t    out_status;
  status_t    out_status_next;
  entry_t     out_entry;
  entry_t     out_entry_next;
  logic       out_last;
  logic       out_last_next;
  logic       out_free;

  logic       hv;
  logic       hv_next;
  logic       held_ld;
  entry_t     held;
  logic [RPT_W-1:0] rpt_cnt;
  logic [RPT_W-1:0] rpt_cnt_next;

  logic       s_acc;
  logic       expire;
  logic       report;
  entry_t     head_dec;
  entry_t     head_zero;

  assign s_acc    = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;

  assign valid[TABLE_DEPTH]   = 1'b0;
  assign pending[TABLE_DEPTH] = 1'b0;
  assign entries[TABLE_DEPTH] = '0;
  assign hit[0]               = 1'b0;

  for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_cell
    ctt_cell u_cell (
      .clk          (clk),
      .rst          (rst),
      .cmd          (cmd),
      .prev_valid   ((j == 0) ? 1'b1 : valid[(j == 0) ? 0 : j - 1]),
      .next_valid   (valid[j + 1]),
      .next_pending (pending[j + 1]),
      .next_entry   (entries[j + 1]),
      .hit_in       (hit[j]),
      .hit_out      (hit[j + 1]),
      .first        (first[j]),
      .valid        (valid[j]),
      .pending      (pending[j]),
      .entry        (entries[j])
    );
  end

  always_comb begin
    sel = '0;
    for (int j = 0; j < TABLE_DEPTH; j++) begin
      sel = sel | (first[j] ? entries[j] : '0);
    end
  end

  always_comb begin
    head_dec        = entries[0];
    head_dec.ticks  = entries[0].ticks - 16'd1;
    head_zero       = entries[0];
    head_zero.ticks = '0;
    expire          = (entries[0].ticks <= 16'd1);
    report          = expire && (rpt_cnt < RPT_W'(MAX_RESULTS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    s_tready        = 1'b0;
    cmd.op          = CO_HOLD;
    cmd.keep        = 1'b0;
    cmd.bus         = key_r;
    out_ld          = 1'b0;
    out_status_next = STAT_ADDED;
    out_entry_next  = key_r;
    out_entry_next.ticks = '0;
    out_last_next   = 1'b1;
    hv_next         = hv;
    held_ld         = 1'b0;
    rpt_cnt_next    = rpt_cnt;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_acc) begin
          if (opcode_t'(s_tuser) == OP_TICK) begin
            cmd.op       = CO_MARK;
            hv_next      = 1'b0;
            rpt_cnt_next = '0;
            state_next   = S_TICK;
          end else begin
            state_next = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (out_free) begin
          out_ld     = 1'b1;
          state_next = S_IDLE;
          unique case (op_r)
            OP_ADD: begin
              cmd.op          = CO_ADD;
              out_status_next = valid[TABLE_DEPTH - 1] ? STAT_FULL : STAT_ADDED;
            end
            OP_FIND: begin
              if (hit[TABLE_DEPTH]) begin
                out_status_next = STAT_FOUND;
                out_entry_next  = sel;
              end else begin
                out_status_next = STAT_MISSING;
              end
            end
            OP_REMOVE: begin
              cmd.op = CO_REMOVE;
              if (hit[TABLE_DEPTH]) begin
                out_status_next      = STAT_REMOVED;
                out_entry_next       = sel;
                out_entry_next.ticks = '0;
              end else begin
                out_status_next = STAT_MISSING;
              end
            end
            default: begin
              out_ld     = 1'b0;
            end
          endcase
        end
      end
      S_TICK: begin
        out_status_next = STAT_TIMEOUT;
        out_entry_next  = held;
        if (valid[0] && pending[0]) begin
          if (!(report && hv && !out_free)) begin
            cmd.op   = CO_ROTATE;
            cmd.keep = !expire;
            cmd.bus  = head_dec;
            if (report) begin
              out_ld        = hv;
              out_last_next = 1'b0;
              held_ld       = 1'b1;
              hv_next       = 1'b1;
              rpt_cnt_next  = rpt_cnt + RPT_W'(1);
            end
          end
        end else if (!hv) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          out_ld     = 1'b1;
          hv_next    = 1'b0;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      op_r  <= opcode_t'(s_tuser);
      key_r <= entry_t'(s_tdata);
    end
    if (held_ld) begin
      held <= head_zero;
    end
    if (out_ld) begin
      out_status <= out_status_next;
      out_entry  <= out_entry_next;
      out_last   <= out_last_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      hv        <= 1'b0;
      rpt_cnt   <= '0;
    end else begin
      hv      <= hv_next;
      rpt_cnt <= rpt_cnt_next;
      if (out_ld) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_entry;
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;

endmodule

[hw/rtl/ctt_checker.sv]
// Port-level checks for the confirmation timeout table, bound to the top level.
`timescale 1ns / 1ps
module ctt_checker import ctt_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata,   // out_port, out_hw_addr, out_smb, out_msg_id, out_ticks_left
  input logic [2:0]  m_tuser,   // status
  input logic        m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != STAT_TIMEOUT) |-> m_tlast)
    else $error("single result without last mark");

  a_ticks_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != STAT_FOUND) |-> (m_tdata[79:64] == 16'd0))
    else $error("ticks left nonzero on a result other than found");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("new transaction taken while the previous one is in work");

endmodule

bind confirmation_timeout_table ctt_checker u_ctt_checker (.*);
